@@ hw/rtl/gaussian_bilinear_tap_weights_macros.svh @@
// assertion macros shared by the tap weight generator
`ifndef GAUSSIAN_BILINEAR_TAP_WEIGHTS_MACROS_SVH
`define GAUSSIAN_BILINEAR_TAP_WEIGHTS_MACROS_SVH

// same-cycle implication, checked outside reset
`define GBTW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define GBTW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ hw/rtl/gbtw_pkg.sv @@
// shared types and constants of the tap weight generator
package gbtw_pkg;

	// fixed point one in Q1.30
	localparam logic [30:0] FX_ONE = 31'h4000_0000;
	localparam int SER_TERMS = 16;
	localparam int EXP_INT_LIMIT = 40;

	// serial divider sizes
	localparam int DIV_W = 56;
	localparam int DVS_W = 33;
	localparam int NB_W = 6;

	// dividend bit counts per division kind
	localparam logic [NB_W-1:0] NB_ARG = 6'd55;
	localparam logic [NB_W-1:0] NB_SER = 6'd31;
	localparam logic [NB_W-1:0] NB_OFF = 6'd44;
	localparam logic [NB_W-1:0] NB_NRM = 6'd45;

	// division kinds
	localparam logic [1:0] DIV_ARG = 2'd0;
	localparam logic [1:0] DIV_SER = 2'd1;
	localparam logic [1:0] DIV_OFF = 2'd2;
	localparam logic [1:0] DIV_NRM = 2'd3;

	localparam int SUMW_W = 36;
	localparam int TAP_W = 3;
	localparam int OUT_W = 16;

	typedef struct packed {
		logic       ld_sigma;
		logic       sumw_clr;
		logic       idx_clr;
		logic       idx_inc;
		logic       half;
		logic       x_one;
		logic       ser_init;
		logic       mul_e1;
		logic       div_start;
		logic [1:0] div_mode;
		logic       r_ser;
		logic       e1_ld;
		logic       arg_ld;
		logic       r_zero;
		logic       pow_wr;
		logic       w_ld;
		logic       sum_ld;
		logic       store;
		logic       tot_ld;
		logic       rd;
		logic       emit;
		logic       emit_bad;
	} cmd_t;

	typedef struct packed {
		logic sigma_zero;
		logic div_done;
		logic arg_big;
		logic n_one;
		logic n_zero;
		logic k_one;
		logic sum_zero;
		logic total_zero;
		logic idx_last;
	} sts_t;

endpackage

@@ hw/rtl/gbtw_div.sv @@
// shared restoring divider, one quotient bit per cycle
module gbtw_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [gbtw_pkg::DIV_W-1:0]  dividend,
	input  logic [gbtw_pkg::DVS_W-1:0]  divisor,
	input  logic [gbtw_pkg::NB_W-1:0]   nbits,
	output logic [gbtw_pkg::DIV_W-1:0]  quo,
	output logic                        done
);

	logic [gbtw_pkg::NB_W-1:0]  cnt_q;
	logic [gbtw_pkg::DVS_W-1:0] rem_q;
	logic [gbtw_pkg::DVS_W-1:0] dvs_q;
	logic [gbtw_pkg::DIV_W-1:0] quo_q;
	logic [gbtw_pkg::DVS_W:0]   trial;
	logic [gbtw_pkg::DVS_W:0]   diff;
	logic                       ge;

	// dividend arrives left aligned, its bits leave at the top
	assign trial = {rem_q, quo_q[gbtw_pkg::DIV_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= nbits;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[gbtw_pkg::DVS_W-1:0] : trial[gbtw_pkg::DVS_W-1:0];
			quo_q <= {quo_q[gbtw_pkg::DIV_W-2:0], ge};
		end
	end

	assign quo  = quo_q;
	assign done = (cnt_q == '0);

endmodule

@@ hw/rtl/gbtw_dp.sv @@
// datapath: operand registers, multiplier, stores and output registers
module gbtw_dp #(
	parameter int TAP_PAIRS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [15:0]                 sigma,
	input  gbtw_pkg::cmd_t              cmd,
	output gbtw_pkg::sts_t              sts,
	output logic [gbtw_pkg::TAP_W-1:0]  tap,
	output logic [gbtw_pkg::OUT_W-1:0]  weight,
	output logic [gbtw_pkg::OUT_W-1:0]  offset,
	output logic                        bad_sigma,
	output logic                        last
);

	localparam int IW = (TAP_PAIRS > 1) ? $clog2(TAP_PAIRS) : 1;
	localparam int QW = IW + 1;

	logic [15:0]                s_q;
	logic [31:0]                s2_q;
	logic [30:0]                x_q;
	logic [30:0]                r_q;
	logic [30:0]                e1_q;
	logic [61:0]                prod_q;
	logic [5:0]                 n_q;
	logic [4:0]                 k_q;
	logic [30:0]                w0_q;
	logic [30:0]                w1_q;
	logic [31:0]                sum_q;
	logic [gbtw_pkg::SUMW_W-1:0] sumw_q;
	logic [31:0]                total_q;
	logic [IW-1:0]              idx_q;
	logic [31:0]                raw_mem [TAP_PAIRS];
	logic [15:0]                off_mem [TAP_PAIRS];
	logic [31:0]                rd_w_q;
	logic [15:0]                rd_off_q;
	logic [gbtw_pkg::TAP_W-1:0] tap_q;
	logic [15:0]                weight_q;
	logic [15:0]                offset_q;
	logic                       bad_q;
	logic                       last_q;

	logic [QW-1:0]              q;
	logic [2*QW-1:0]            q2;
	logic [gbtw_pkg::DIV_W-1:0] dividend;
	logic [gbtw_pkg::DVS_W-1:0] divisor;
	logic [gbtw_pkg::NB_W-1:0]  nbits;
	logic [gbtw_pkg::DIV_W-1:0] quo;
	logic                       div_done;
	logic [30:0]                mul_a;
	logic [30:0]                ser_r;
	logic [17:0]                off_full;
	logic [15:0]                off_sat;
	logic [15:0]                w_sat;
	logic                       idx_last;

	assign q        = {idx_q, cmd.half};
	assign q2       = q * q;
	assign idx_last = (idx_q == IW'(TAP_PAIRS - 1));
	assign mul_a    = cmd.mul_e1 ? e1_q : x_q;

	// operands left aligned for the divider
	always_comb begin
		case (cmd.div_mode)
			gbtw_pkg::DIV_ARG: begin
				dividend = gbtw_pkg::DIV_W'(q2) << 46;
				divisor  = gbtw_pkg::DVS_W'(s2_q);
				nbits    = gbtw_pkg::NB_ARG;
			end
			gbtw_pkg::DIV_SER: begin
				dividend = gbtw_pkg::DIV_W'(prod_q[60:30]) << 25;
				divisor  = gbtw_pkg::DVS_W'(k_q);
				nbits    = gbtw_pkg::NB_SER;
			end
			gbtw_pkg::DIV_OFF: begin
				dividend = ((gbtw_pkg::DIV_W'(w1_q) << 13) + gbtw_pkg::DIV_W'(sum_q)) << 12;
				divisor  = {sum_q, 1'b0};
				nbits    = gbtw_pkg::NB_OFF;
			end
			default: begin
				dividend = ((gbtw_pkg::DIV_W'(rd_w_q) << 13) + gbtw_pkg::DIV_W'(total_q)) << 11;
				divisor  = {total_q, 1'b0};
				nbits    = gbtw_pkg::NB_NRM;
			end
		endcase
	end

	gbtw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.nbits    (nbits),
		.quo      (quo),
		.done     (div_done)
	);

	// one series step: r = 1 - t, floored at zero
	assign ser_r = (|quo[gbtw_pkg::DIV_W-1:30]) ? 31'd0 : gbtw_pkg::FX_ONE - quo[30:0];

	assign off_full = (18'({idx_q, 1'b0}) << 12) + (sts.sum_zero ? 18'd0 : 18'(quo[12:0]));
	assign off_sat  = (off_full > 18'h0FFFF) ? 16'hFFFF : off_full[15:0];
	assign w_sat    = (|quo[gbtw_pkg::DIV_W-1:16]) ? 16'hFFFF : quo[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			n_q     <= '0;
			k_q     <= '0;
			total_q <= '0;
		end else begin
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.arg_ld) begin
				n_q <= quo[35:30];
			end else if (cmd.pow_wr) begin
				n_q <= n_q - 1'b1;
			end
			if (cmd.ser_init) begin
				k_q <= 5'(gbtw_pkg::SER_TERMS);
			end else if (cmd.r_ser) begin
				k_q <= k_q - 1'b1;
			end
			if (cmd.tot_ld) begin
				total_q <= sumw_q[34:3];
			end
		end
	end

	always_ff @(posedge clk) begin
		s2_q   <= s_q * s_q;
		prod_q <= mul_a * r_q;
		if (cmd.ld_sigma) begin
			s_q <= sigma;
		end
		if (cmd.x_one) begin
			x_q <= gbtw_pkg::FX_ONE;
		end else if (cmd.arg_ld) begin
			x_q <= {1'b0, quo[29:0]};
		end
		if (cmd.ser_init) begin
			r_q <= gbtw_pkg::FX_ONE;
		end else if (cmd.r_ser) begin
			r_q <= ser_r;
		end else if (cmd.r_zero) begin
			r_q <= '0;
		end else if (cmd.pow_wr) begin
			r_q <= prod_q[60:30];
		end
		if (cmd.e1_ld) begin
			e1_q <= r_q;
		end
		if (cmd.w_ld) begin
			if (!cmd.half) begin
				w0_q <= (idx_q == '0) ? (r_q >> 1) : r_q;
			end else begin
				w1_q <= r_q;
			end
		end
		if (cmd.sum_ld) begin
			sum_q <= 32'(w0_q) + 32'(w1_q);
		end
		if (cmd.sumw_clr) begin
			sumw_q <= '0;
		end else if (cmd.store) begin
			sumw_q <= sumw_q + gbtw_pkg::SUMW_W'(sum_q);
		end
		if (cmd.store) begin
			raw_mem[idx_q] <= sum_q;
			off_mem[idx_q] <= off_sat;
		end
		if (cmd.rd) begin
			rd_w_q   <= raw_mem[idx_q];
			rd_off_q <= off_mem[idx_q];
		end
		if (cmd.emit || cmd.emit_bad) begin
			tap_q    <= gbtw_pkg::TAP_W'(idx_q);
			last_q   <= idx_last;
			bad_q    <= cmd.emit_bad;
			weight_q <= (cmd.emit_bad || sts.total_zero) ? 16'd0 : w_sat;
			offset_q <= cmd.emit_bad ? 16'd0 : rd_off_q;
		end
	end

	always_comb begin
		sts.sigma_zero = (s_q == '0);
		sts.div_done   = div_done;
		sts.arg_big    = (quo[gbtw_pkg::DIV_W-1:30] >= 26'(gbtw_pkg::EXP_INT_LIMIT));
		sts.n_one      = (n_q == 6'd1);
		sts.n_zero     = (n_q == '0);
		sts.k_one      = (k_q == 5'd1);
		sts.sum_zero   = (sum_q == '0);
		sts.total_zero = (total_q == '0);
		sts.idx_last   = idx_last;
	end

	assign tap       = tap_q;
	assign weight    = weight_q;
	assign offset    = offset_q;
	assign bad_sigma = bad_q;
	assign last      = last_q;

endmodule

@@ hw/rtl/gbtw_ctrl.sv @@
// controller state machine sequencing the datapath
`include "gaussian_bilinear_tap_weights_macros.svh"

module gbtw_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  gbtw_pkg::sts_t  sts,
	output gbtw_pkg::cmd_t  cmd,
	output logic            busy,
	output logic            strobe
);

	localparam logic [4:0] S_IDLE      = 5'd0;
	localparam logic [4:0] S_CHECK     = 5'd1;
	localparam logic [4:0] S_SER_MUL   = 5'd2;
	localparam logic [4:0] S_SER_DIVST = 5'd3;
	localparam logic [4:0] S_SER_DIVW  = 5'd4;
	localparam logic [4:0] S_SER_END   = 5'd5;
	localparam logic [4:0] S_G_DIVST   = 5'd6;
	localparam logic [4:0] S_G_DIVW    = 5'd7;
	localparam logic [4:0] S_POW_MUL   = 5'd8;
	localparam logic [4:0] S_POW_WR    = 5'd9;
	localparam logic [4:0] S_G_DONE    = 5'd10;
	localparam logic [4:0] S_SUM       = 5'd11;
	localparam logic [4:0] S_OFF_CHK   = 5'd12;
	localparam logic [4:0] S_OFF_DIVST = 5'd13;
	localparam logic [4:0] S_OFF_DIVW  = 5'd14;
	localparam logic [4:0] S_STORE     = 5'd15;
	localparam logic [4:0] S_TOT       = 5'd16;
	localparam logic [4:0] S_O_RD      = 5'd17;
	localparam logic [4:0] S_O_CHK     = 5'd18;
	localparam logic [4:0] S_O_DIVST   = 5'd19;
	localparam logic [4:0] S_O_DIVW    = 5'd20;
	localparam logic [4:0] S_O_EMIT    = 5'd21;
	localparam logic [4:0] S_BAD       = 5'd22;

	logic [4:0] state_q, state_d;
	logic       ret_e1_q, ret_e1_d;
	logic       half_q, half_d;
	logic       strobe_q, strobe_d;
	logic       emit_any;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		ret_e1_d = ret_e1_q;
		half_d   = half_q;
		strobe_d = 1'b0;
		cmd.half = half_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.ld_sigma = 1'b1;
					cmd.sumw_clr = 1'b1;
					cmd.idx_clr  = 1'b1;
					state_d      = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.sigma_zero) begin
					state_d = S_BAD;
				end else begin
					cmd.x_one    = 1'b1;
					cmd.ser_init = 1'b1;
					ret_e1_d     = 1'b1;
					half_d       = 1'b0;
					state_d      = S_SER_MUL;
				end
			end
			S_SER_MUL: begin
				state_d = S_SER_DIVST;
			end
			S_SER_DIVST: begin
				cmd.div_start = 1'b1;
				cmd.div_mode  = gbtw_pkg::DIV_SER;
				state_d       = S_SER_DIVW;
			end
			S_SER_DIVW: begin
				cmd.div_mode = gbtw_pkg::DIV_SER;
				if (sts.div_done) begin
					cmd.r_ser = 1'b1;
					state_d   = sts.k_one ? S_SER_END : S_SER_MUL;
				end
			end
			S_SER_END: begin
				if (ret_e1_q) begin
					cmd.e1_ld = 1'b1;
					ret_e1_d  = 1'b0;
					state_d   = S_G_DIVST;
				end else begin
					state_d = sts.n_zero ? S_G_DONE : S_POW_MUL;
				end
			end
			S_G_DIVST: begin
				cmd.div_start = 1'b1;
				cmd.div_mode  = gbtw_pkg::DIV_ARG;
				state_d       = S_G_DIVW;
			end
			S_G_DIVW: begin
				cmd.div_mode = gbtw_pkg::DIV_ARG;
				if (sts.div_done) begin
					cmd.arg_ld = 1'b1;
					if (sts.arg_big) begin
						cmd.r_zero = 1'b1;
						state_d    = S_G_DONE;
					end else begin
						cmd.ser_init = 1'b1;
						state_d      = S_SER_MUL;
					end
				end
			end
			S_POW_MUL: begin
				cmd.mul_e1 = 1'b1;
				state_d    = S_POW_WR;
			end
			S_POW_WR: begin
				cmd.pow_wr = 1'b1;
				state_d    = sts.n_one ? S_G_DONE : S_POW_MUL;
			end
			S_G_DONE: begin
				cmd.w_ld = 1'b1;
				if (!half_q) begin
					half_d  = 1'b1;
					state_d = S_G_DIVST;
				end else begin
					state_d = S_SUM;
				end
			end
			S_SUM: begin
				cmd.sum_ld = 1'b1;
				state_d    = S_OFF_CHK;
			end
			S_OFF_CHK: begin
				state_d = sts.sum_zero ? S_STORE : S_OFF_DIVST;
			end
			S_OFF_DIVST: begin
				cmd.div_start = 1'b1;
				cmd.div_mode  = gbtw_pkg::DIV_OFF;
				state_d       = S_OFF_DIVW;
			end
			S_OFF_DIVW: begin
				cmd.div_mode = gbtw_pkg::DIV_OFF;
				if (sts.div_done) begin
					state_d = S_STORE;
				end
			end
			S_STORE: begin
				cmd.store = 1'b1;
				half_d    = 1'b0;
				if (sts.idx_last) begin
					state_d = S_TOT;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_G_DIVST;
				end
			end
			S_TOT: begin
				cmd.tot_ld  = 1'b1;
				cmd.idx_clr = 1'b1;
				state_d     = S_O_RD;
			end
			S_O_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_O_CHK;
			end
			S_O_CHK: begin
				state_d = sts.total_zero ? S_O_EMIT : S_O_DIVST;
			end
			S_O_DIVST: begin
				cmd.div_start = 1'b1;
				cmd.div_mode  = gbtw_pkg::DIV_NRM;
				state_d       = S_O_DIVW;
			end
			S_O_DIVW: begin
				cmd.div_mode = gbtw_pkg::DIV_NRM;
				if (sts.div_done) begin
					state_d = S_O_EMIT;
				end
			end
			S_O_EMIT: begin
				cmd.emit = 1'b1;
				strobe_d = 1'b1;
				if (sts.idx_last) begin
					state_d = S_IDLE;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_O_RD;
				end
			end
			S_BAD: begin
				cmd.emit_bad = 1'b1;
				strobe_d     = 1'b1;
				if (sts.idx_last) begin
					state_d = S_IDLE;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ret_e1_q <= 1'b0;
			half_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			ret_e1_q <= ret_e1_d;
			half_q   <= half_d;
			strobe_q <= strobe_d;
		end
	end

	assign busy     = (state_q != S_IDLE);
	assign strobe   = strobe_q;
	assign emit_any = (state_q == S_O_EMIT) || (state_q == S_BAD);

	`GBTW_ASSERT_NEXT(a_emit_strobe, clk, arst_n, emit_any, strobe_q)
	`GBTW_ASSERT_IMPL(a_strobe_src, clk, arst_n, strobe_q, $past(emit_any))
	`GBTW_ASSERT_IMPL(a_div_free, clk, arst_n, cmd.div_start, sts.div_done)
	`GBTW_ASSERT_NEXT(a_last_idle, clk, arst_n, emit_any && sts.idx_last, state_q == S_IDLE)

endmodule

@@ hw/rtl/gaussian_bilinear_tap_weights.sv @@
// top level of the gaussian bilinear tap weight generator
//
//  channel  | handshake        | payload
//  ---------+------------------+-------------------------------------------
//  input    | start, busy      | sigma (unsigned q8.8)
//  result   | strobe           | tap, weight, offset, bad_sigma, last
//
// one item gives TAP_PAIRS results, one per tap pair, in tap order
// time per item is set by the shared serial divider (one quotient bit a
// cycle); for the default 8 tap pairs it runs 17 exponentials of
// 16 series terms each (an argument of 40 or more skips its series), plus
// argument, offset and normalize divisions; results leave one by one
// zero sigma: results come out back to back
// reset clears the controller and weight total; stores hold garbage until written
// strobe marks each result for one cycle, the receiver cannot stall
module gaussian_bilinear_tap_weights #(
	parameter int TAP_PAIRS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [15:0]                 sigma,
	output logic                        strobe,
	output logic [gbtw_pkg::TAP_W-1:0]  tap,
	output logic [gbtw_pkg::OUT_W-1:0]  weight,
	output logic [gbtw_pkg::OUT_W-1:0]  offset,
	output logic                        bad_sigma,
	output logic                        last
);

	// command and status between sequencer and datapath
	gbtw_pkg::cmd_t cmd;
	gbtw_pkg::sts_t sts;

	// datapath: multiplier, shared divider, weight/offset stores, result regs
	gbtw_dp #(
		.TAP_PAIRS (TAP_PAIRS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.sigma     (sigma),
		.cmd       (cmd),
		.sts       (sts),
		.tap       (tap),
		.weight    (weight),
		.offset    (offset),
		.bad_sigma (bad_sigma),
		.last      (last)
	);

	// sequencer: exp series, power loop, per-tap stores, then output sweep
	gbtw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.strobe (strobe)
	);

endmodule

@@ dv/tb_gaussian_bilinear_tap_weights.sv @@
// self-checking testbench for the gaussian bilinear tap weight generator
`timescale 1ns / 100ps

module tb_gaussian_bilinear_tap_weights;

	localparam int TAPS = 8;
	localparam int QUIET_LIMIT = 200000;  // cycles without an accepted item or a result before giving up, allow plenty
	localparam int TAIL_CYCLES = 64;

	typedef struct packed {
		logic [2:0]  tap;
		logic [15:0] weight;
		logic [15:0] offset;
		logic        bad_sigma;
		logic        last;
	} tap_res_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [15:0] sigma;
	logic        strobe;
	logic [2:0]  tap;
	logic [15:0] weight;
	logic [15:0] offset;
	logic        bad_sigma;
	logic        last;

	gaussian_bilinear_tap_weights #(.TAP_PAIRS(TAPS)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sigma(sigma),
		.strobe(strobe), .tap(tap), .weight(weight), .offset(offset),
		.bad_sigma(bad_sigma), .last(last)
	);

	logic [15:0] sigma_q[$];      // items waiting to be sent
	tap_res_t    tap_res_q[$];    // predicted tap results, oldest first
	int          n_errors = 0;
	int          quiet_cycles = 0;
	int          gap_left = 0;
	bit          just_sent = 0;
	bit          drain_done = 0;
	bit          drain_on = 0;

	always #5 clk = ~clk;

	// exp(-x), x in q1.30 within [0,1], truncating horner series
	function automatic longint unsigned exp_frac(longint unsigned x);
		longint unsigned r;
		longint unsigned t;
		r = 64'd1 << 30;
		for (int k = 16; k >= 1; k--) begin
			t = ((x * r) >> 30) / k;
			r = (t >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - t;
		end
		return r;
	endfunction

	// exp(-a), a in unsigned q.30: integer part by repeated exp(-1) products
	function automatic longint unsigned exp_q30(longint unsigned a);
		longint unsigned n;
		longint unsigned r;
		longint unsigned e1;
		n = a >> 30;
		if (n >= 40)
			return 0;
		r = exp_frac(a & ((64'd1 << 30) - 1));
		e1 = exp_frac(64'd1 << 30);
		for (longint unsigned i = 0; i < n; i++)
			r = (r * e1) >> 30;
		return r;
	endfunction

	// exp(-q^2 / (2 sigma^2)) with sigma in q8.8
	function automatic longint unsigned gauss_q30(int unsigned q, logic [15:0] s);
		longint unsigned s2;
		longint unsigned num;
		s2 = longint'(s) * longint'(s);
		num = (longint'(q) * longint'(q)) << 45;
		return exp_q30(num / s2);
	endfunction

	// push the eight tap results one sigma should produce
	task automatic predict_taps(logic [15:0] s);
		longint unsigned pair_w[TAPS];
		longint unsigned pair_off[TAPS];
		longint unsigned w0, w1, sum, off, total, wq, sumw;
		tap_res_t r;
		sumw = 0;
		for (int i = 0; i < TAPS; i++) begin
			w0 = gauss_q30(2 * i, s);
			w1 = gauss_q30(2 * i + 1, s);
			if (i == 0)
				w0 = w0 >> 1;          // center tap is shared by both sides
			sum = w0 + w1;
			if (sum == 0)
				off = longint'(2 * i) << 12;   // underflow: plain texel position
			else
				off = (longint'(2 * i) << 12) + ((w1 * 8192 + sum) / (2 * sum));
			if (off > 16'hFFFF)
				off = 16'hFFFF;
			pair_w[i] = sum & 32'hFFFF_FFFF;
			pair_off[i] = off;
			sumw += sum;
		end
		total = (sumw >> 3) & 32'hFFFF_FFFF;
		for (int i = 0; i < TAPS; i++) begin
			wq = 0;
			if (s != 0 && total != 0) begin
				wq = (pair_w[i] * 8192 + total) / (2 * total);
				if (wq > 16'hFFFF)
					wq = 16'hFFFF;
			end
			r.tap = i[2:0];
			r.weight = wq[15:0];
			r.offset = (s == 0) ? 16'd0 : pair_off[i][15:0];
			r.bad_sigma = (s == 0);
			r.last = (i == TAPS - 1);
			tap_res_q.push_back(r);
		end
	endtask

	task automatic report_mismatch(string what, int got, int want);
		n_errors++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	// driver: presents the next sigma on the falling edge, with random gaps
	// that start counting once the block is idle again
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (drain_on && tap_res_q.size() != 0) begin
			start <= 1'b0;             // hold off until every tap result is out
		end else if (gap_left > 0) begin
			if (!busy)
				gap_left <= gap_left - 1;
			start <= 1'b0;
		end else if (just_sent && sigma_q.size() > 30 && $urandom_range(0, 3) == 0) begin
			gap_left <= $urandom_range(1, 18);
			start <= 1'b0;
		end else if (sigma_q.size() != 0) begin
			start <= 1'b1;
			sigma <= sigma_q[0];
		end else begin
			start <= 1'b0;
		end
		if (drain_on && tap_res_q.size() == 0)
			drain_on <= 1'b0;
	end

	// monitor: takes accepted items and results on the rising edge
	always @(posedge clk) begin
		just_sent <= arst_n && start && !busy;
		if (arst_n) begin
			quiet_cycles <= ((start && !busy) || strobe) ? 0 : quiet_cycles + 1;
			if (start && !busy) begin
				predict_taps(sigma);
				void'(sigma_q.pop_front());
				// one pause half way through until the block has drained
				if (!drain_done && sigma_q.size() == 100) begin
					drain_on <= 1'b1;
					drain_done <= 1'b1;
				end
			end
			if (strobe) begin
				if (tap_res_q.size() == 0) begin
					n_errors++;
					$display("tap result with nothing expected at %0t", $realtime);
				end else begin
					tap_res_t e;
					e = tap_res_q.pop_front();
					if (tap !== e.tap)
						report_mismatch("tap", tap, e.tap);
					if (weight !== e.weight)
						report_mismatch("weight", weight, e.weight);
					if (offset !== e.offset)
						report_mismatch("offset", offset, e.offset);
					if (bad_sigma !== e.bad_sigma)
						report_mismatch("bad_sigma", bad_sigma, e.bad_sigma);
					if (last !== e.last)
						report_mismatch("last", last, e.last);
				end
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		sigma = 16'd0;

		// directed: invalid zero, extremes, tiny sigma (all but center underflow),
		// common blur widths, and some bit pattern extremes
		sigma_q.push_back(16'h0000);
		sigma_q.push_back(16'h0001);
		sigma_q.push_back(16'hFFFF);
		sigma_q.push_back(16'h0000);
		sigma_q.push_back(16'h0010);
		sigma_q.push_back(16'h0040);
		sigma_q.push_back(16'h0080);
		sigma_q.push_back(16'h0100);
		sigma_q.push_back(16'h0180);
		sigma_q.push_back(16'h0200);
		sigma_q.push_back(16'h0400);
		sigma_q.push_back(16'h0800);
		sigma_q.push_back(16'h1000);
		sigma_q.push_back(16'h8000);
		sigma_q.push_back(16'h5555);
		sigma_q.push_back(16'hAAAA);
		sigma_q.push_back(16'h00FF);

		// random: mostly useful blur widths, some anywhere, a few invalid
		for (int i = 0; i < 190; i++) begin
			case ($urandom_range(0, 9))
				0:       sigma_q.push_back(16'h0000);
				1, 2:    sigma_q.push_back(16'($urandom_range(1, 16'hFFFF)));
				3:       sigma_q.push_back(16'($urandom_range(1, 16'h00FF)));
				default: sigma_q.push_back(16'($urandom_range(16'h0080, 16'h0C00)));
			endcase
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (sigma_q.size() == 0 && tap_res_q.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/gbtw_pkg.sv
hw/rtl/gbtw_div.sv
hw/rtl/gbtw_dp.sv
hw/rtl/gbtw_ctrl.sv
hw/rtl/gaussian_bilinear_tap_weights.sv
dv/tb_gaussian_bilinear_tap_weights.sv
